[rtl/mpa_pkg.sv]
// Package for the 2x2 max pooling block with argmax.
// Holds register indexes, item class codes, the pipeline tag type and the size clamp.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mpa_pkg;

	// Fixed field widths.
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 4;
	localparam int POS_W     = 9;

	// Defaults for the top-level parameters.
	localparam int DEF_MAX_COLS  = 1024;
	localparam int DEF_MAX_ROWS  = 1024;
	localparam int DEF_PIX_WIDTH = 16;

	// Frame size after reset and smallest usable size.
	localparam logic [CFG_W-1:0] SIZE_MIN = 11'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 4'd1;

	// Class of a pixel within the pooling grid.
	typedef logic [1:0] mpa_kind_t;
	localparam mpa_kind_t KIND_SKIP   = 2'd0;
	localparam mpa_kind_t KIND_LEFT   = 2'd1;
	localparam mpa_kind_t KIND_TOP    = 2'd2;
	localparam mpa_kind_t KIND_BOTTOM = 2'd3;

	// Control tag that travels with each pixel from the sequencer to the datapath.
	typedef struct packed {
		mpa_kind_t        kind;
		logic             last;
		logic [POS_W-1:0] out_row;
		logic [POS_W-1:0] out_col;
	} mpa_tag_t;

	// A size below the minimum is used as the minimum, one above maxv as maxv.
	function automatic logic [31:0] clamp_size(logic [CFG_W-1:0] v, logic [31:0] maxv);
		logic [31:0] vx;
		vx = 32'(v);
		if (v < SIZE_MIN) begin
			clamp_size = 32'(SIZE_MIN);
		end else if (vx > maxv) begin
			clamp_size = maxv;
		end else begin
			clamp_size = vx;
		end
	endfunction

endpackage

`default_nettype wire

[rtl/mpa_if.sv]
// Channel interfaces of the 2x2 max pooling block: pixel stream, result stream
// and configuration writes. Depends on mpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Pixel stream, one signed pixel per request.
interface mpa_pix_if #(
	parameter int PIX_WIDTH = mpa_pkg::DEF_PIX_WIDTH
);
	logic                 valid;
	logic                 ready;
	logic [PIX_WIDTH-1:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface

// Result stream, one pooled window per request.
interface mpa_res_if #(
	parameter int PIX_WIDTH = mpa_pkg::DEF_PIX_WIDTH
);
	logic                          valid;
	logic                          ready;
	logic [PIX_WIDTH-2:0]          pooled_value;
	logic                          win_row_offset;
	logic                          win_col_offset;
	logic [mpa_pkg::POS_W-1:0]     out_row;
	logic [mpa_pkg::POS_W-1:0]     out_col;
	logic                          frame_last;

	modport source (output valid, output pooled_value, output win_row_offset,
		output win_col_offset, output out_row, output out_col, output frame_last,
		input ready);
	modport sink (input valid, input pooled_value, input win_row_offset,
		input win_col_offset, input out_row, input out_col, input frame_last,
		output ready);
endinterface

// Configuration write channel.
interface mpa_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [mpa_pkg::CFG_IDX_W-1:0] index;
	logic [mpa_pkg::CFG_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/mpa_pair_mem.sv]
// Store of the best top-row pair per window column, one write and one read port.
// Depends on nothing; the read data is registered.
`timescale 1ns / 1ps
`default_nettype none

module mpa_pair_mem #(
	parameter int DEPTH = 512,
	parameter int AW    = 9,
	parameter int DW    = 16
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

[rtl/mpa_ctrl.sv]
// Frame sequencer: configuration registers, row and column counters, and the
// class tag of each incoming pixel. Depends on mpa_pkg and mpa_if.
`timescale 1ns / 1ps
`default_nettype none

module mpa_ctrl
	import mpa_pkg::*;
#(
	parameter int MAX_COLS = DEF_MAX_COLS,
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int PW       = 9
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	mpa_cfg_if.sink      cfg,
	input  wire logic    accept,
	output mpa_tag_t     tag,
	output logic [PW-1:0] pair
);

	localparam int RNW = $clog2(MAX_ROWS + 1);
	localparam int CNW = $clog2(MAX_COLS + 1);

	logic [RNW-1:0] rows_q;
	logic [CNW-1:0] cols_q;
	logic [RNW-1:0] row_q;
	logic [CNW-1:0] col_q;

	logic [RNW-1:0] rows_even;
	logic [CNW-1:0] cols_even;
	logic [RNW-1:0] row_inc;
	logic [CNW-1:0] col_inc;
	logic           in_area;

	assign cfg.ready = 1'b1;

	// Sizes cut down to whole windows.
	assign rows_even = rows_q & ~RNW'(1);
	assign cols_even = cols_q & ~CNW'(1);
	assign row_inc   = row_q + RNW'(1);
	assign col_inc   = col_q + CNW'(1);
	assign in_area   = (row_q < rows_even) && (col_q < cols_even);

	// Classify the current pixel and give its window position.
	always_comb begin
		if (!in_area) begin
			tag.kind = KIND_SKIP;
		end else if (!col_q[0]) begin
			tag.kind = KIND_LEFT;
		end else if (!row_q[0]) begin
			tag.kind = KIND_TOP;
		end else begin
			tag.kind = KIND_BOTTOM;
		end
		tag.out_row = POS_W'(row_q >> 1);
		tag.out_col = POS_W'(col_q >> 1);
		tag.last    = (RNW'(row_q >> 1) == RNW'((rows_q >> 1) - RNW'(1)))
			&& (CNW'(col_q >> 1) == CNW'((cols_q >> 1) - CNW'(1)));
	end

	assign pair = PW'(col_q >> 1);

	// Configuration registers; a known register write restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= RNW'(SIZE_MIN);
			cols_q <= CNW'(SIZE_MIN);
			row_q  <= '0;
			col_q  <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_IMAGE_ROWS: begin
					rows_q <= RNW'(clamp_size(cfg.data, 32'(MAX_ROWS)));
					row_q  <= '0;
					col_q  <= '0;
				end
				REG_IMAGE_COLS: begin
					cols_q <= CNW'(clamp_size(cfg.data, 32'(MAX_COLS)));
					row_q  <= '0;
					col_q  <= '0;
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			// Raster scan, wrapping at the end of a row and of the frame.
			if (col_inc >= cols_q) begin
				col_q <= '0;
				row_q <= (row_inc >= rows_q) ? '0 : row_inc;
			end else begin
				col_q <= col_inc;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/mpa_pool_stage.sv]
// Pooling datapath: left pixel hold, input register, pair compares, pair store
// access and the result register. Depends on mpa_pkg and mpa_if.
`timescale 1ns / 1ps
`default_nettype none

module mpa_pool_stage
	import mpa_pkg::*;
#(
	parameter int PIX_WIDTH = DEF_PIX_WIDTH,
	parameter int PW        = 9
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	mpa_pix_if.sink                   pixels,
	mpa_res_if.source                 results,
	input  wire mpa_tag_t             tag,
	input  wire logic [PW-1:0]        pair,
	output logic                      accept,
	output logic                      mem_wr_en,
	output logic [PW-1:0]             mem_wr_addr,
	output logic [PIX_WIDTH-1:0]      mem_wr_data,
	output logic                      mem_rd_en,
	output logic [PW-1:0]             mem_rd_addr,
	input  wire logic [PIX_WIDTH-1:0] mem_rd_data
);

	localparam int VW = PIX_WIDTH - 1;

	logic [VW-1:0] pix_floor;
	logic [VW-1:0] left_q;

	logic          valid_s1;
	mpa_tag_t      tag_s1;
	logic [VW-1:0] pix_s1;
	logic [VW-1:0] left_s1;
	logic [PW-1:0] pair_s1;

	logic          out_valid_q;
	logic          advance;

	logic [VW-1:0] top_best;
	logic          top_off;
	logic [VW-1:0] bot_best;
	logic          bot_roff;
	logic          bot_coff;

	// A negative pixel never beats the zero start value, so it counts as zero.
	assign pix_floor = pixels.pixel[PIX_WIDTH-1] ? '0 : pixels.pixel[VW-1:0];

	// Handshake: the input register frees as soon as the result register can take.
	assign advance      = !out_valid_q || results.ready;
	assign pixels.ready = !valid_s1 || advance;
	assign accept       = pixels.valid && pixels.ready;

	// Left pixel of the current pair.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (accept && tag.kind == KIND_LEFT) begin
			left_q <= pix_floor;
		end
	end

	// Input register holds the right pixel of a pair with its left partner.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixels.ready) begin
			valid_s1 <= accept && (tag.kind == KIND_TOP || tag.kind == KIND_BOTTOM);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tag_s1  <= tag;
			pix_s1  <= pix_floor;
			left_s1 <= left_q;
			pair_s1 <= pair;
		end
	end

	// The top pair of a window is fetched as its bottom right pixel enters.
	assign mem_rd_en   = accept && tag.kind == KIND_BOTTOM;
	assign mem_rd_addr = pair;

	// Best of the top pair; a tie keeps the left pixel.
	always_comb begin
		if (pix_s1 > left_s1) begin
			top_best = pix_s1;
			top_off  = 1'b1;
		end else begin
			top_best = left_s1;
			top_off  = 1'b0;
		end
	end

	// Best of the whole window, the stored top pair winning ties.
	always_comb begin
		bot_best = mem_rd_data[VW-1:0];
		bot_roff = 1'b0;
		bot_coff = mem_rd_data[VW];
		if (left_s1 > bot_best) begin
			bot_best = left_s1;
			bot_roff = 1'b1;
			bot_coff = 1'b0;
		end
		if (pix_s1 > bot_best) begin
			bot_best = pix_s1;
			bot_roff = 1'b1;
			bot_coff = 1'b1;
		end
	end

	// The top pair is stored once, as it leaves the input register.
	assign mem_wr_en   = valid_s1 && advance && tag_s1.kind == KIND_TOP;
	assign mem_wr_addr = pair_s1;
	assign mem_wr_data = {top_off, top_best};

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && tag_s1.kind == KIND_BOTTOM;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && tag_s1.kind == KIND_BOTTOM) begin
			results.pooled_value   <= bot_best;
			results.win_row_offset <= bot_roff;
			results.win_col_offset <= bot_coff;
			results.out_row        <= tag_s1.out_row;
			results.out_col        <= tag_s1.out_col;
			results.frame_last     <= tag_s1.last;
		end
	end

	assign results.valid = out_valid_q;

endmodule

`default_nettype wire

[rtl/max_pool_2x2_with_argmax.sv]
// 2x2 stride-2 max pooling with argmax over a raster-scanned image.
// Top level: joins the frame sequencer, the pooling datapath and the pair store.
// Depends on mpa_pkg, mpa_if, mpa_ctrl, mpa_pool_stage and mpa_pair_mem.
//
// Usage: pixels arrive on the pixel channel in raster order, column fastest,
// one request per pixel. Each full 2x2 window gives one request on the result
// channel carrying the window maximum floored at zero, its row and column
// offset, the window position and a last-of-frame flag. A trailing odd row or
// column is consumed without result. The cfg channel writes image_rows (index 0)
// and image_cols (index 1); it is always ready, and a write to a known index
// restarts the frame. Write it only while no pixel is in flight.
// Timing: a pixel is taken in every cycle while the result channel takes results; a
// result appears once its bottom right pixel has passed the input register and then
// the result register. The pair store is read as that pixel is taken.
// Reset: the frame is 2x2, counters are at the first pixel, no result is
// pending. The pair store is not cleared; each entry is written on an even row
// before the odd row reads it.
// Stall: while a result is not taken, pixels are still taken until the right
// pixel of a pair reaches the input register; the pixel channel then drops
// ready until the result leaves.
`timescale 1ns / 1ps
`default_nettype none

module max_pool_2x2_with_argmax
	import mpa_pkg::*;
#(
	parameter int MAX_COLS  = DEF_MAX_COLS,
	parameter int MAX_ROWS  = DEF_MAX_ROWS,
	parameter int PIX_WIDTH = DEF_PIX_WIDTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	mpa_pix_if.sink   pixels,
	mpa_res_if.source results,
	mpa_cfg_if.sink   cfg
);

	localparam int PAIR_DEPTH = MAX_COLS / 2;
	localparam int PW         = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;

	mpa_tag_t             tag;
	logic [PW-1:0]        pair;
	logic                 accept;
	logic                 mem_wr_en;
	logic [PW-1:0]        mem_wr_addr;
	logic [PIX_WIDTH-1:0] mem_wr_data;
	logic                 mem_rd_en;
	logic [PW-1:0]        mem_rd_addr;
	logic [PIX_WIDTH-1:0] mem_rd_data;

	// Frame sequencer.
	mpa_ctrl #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS),
		.PW       (PW)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.accept (accept),
		.tag    (tag),
		.pair   (pair)
	);

	// Pooling datapath.
	mpa_pool_stage #(
		.PIX_WIDTH (PIX_WIDTH),
		.PW        (PW)
	) u_stage (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixels      (pixels),
		.results     (results),
		.tag         (tag),
		.pair        (pair),
		.accept      (accept),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data)
	);

	// Store of the best top pair per window column.
	mpa_pair_mem #(
		.DEPTH (PAIR_DEPTH),
		.AW    (PW),
		.DW    (PIX_WIDTH)
	) u_pair_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

`ifndef NO_ASSERTIONS
	// A top pair is always stored before its bottom row fetches the same entry.
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_wr_en && mem_rd_en && mem_wr_addr == mem_rd_addr))
		else $error("pair store read and write collide");

	// The pixel channel stalls only behind a result that is not taken.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!pixels.ready |-> (results.valid && !results.ready))
		else $error("pixel channel stalled without output backpressure");

	// A write to a known register restarts the frame at the first window.
	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg.valid && cfg.ready
			&& (cfg.index == REG_IMAGE_ROWS || cfg.index == REG_IMAGE_COLS))
		|=> (tag.out_row == '0 && tag.out_col == '0))
		else $error("configuration write did not restart the frame");
`endif

endmodule

`default_nettype wire

[tb/max_pool_2x2_with_argmax_test.sv]
// Self-checking testbench for the 2x2 max pooling block with argmax.
// A scoreboard class predicts each pooled window from the accepted pixels and
// checks the result stream. Depends on mpa_pkg, mpa_if and the block's RTL.
`timescale 1ns / 1ps

module max_pool_2x2_with_argmax_test;
	import mpa_pkg::*;

	localparam int PIX_W         = DEF_PIX_WIDTH;
	localparam int MAX_C         = DEF_MAX_COLS;
	localparam int MAX_R         = DEF_MAX_ROWS;
	localparam int PAIRS         = MAX_C / 2;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 80;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int MODE_ITEMS    = 340;
	localparam int EDGE_ITEMS    = 48;
	localparam int SHOW_LIMIT    = 30;
	localparam int IDX_TOP       = (1 << CFG_IDX_W) - 1;

	localparam logic [PIX_W-1:0] PIX_MAX = {1'b0, {(PIX_W-1){1'b1}}};
	localparam logic [PIX_W-1:0] PIX_MIN = {1'b1, {(PIX_W-1){1'b0}}};

	// One pooled window as it leaves the block.
	typedef struct packed {
		logic [PIX_W-2:0] value;
		logic             row_off;
		logic             col_off;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             last;
	} window_t;

	// Predicts pooled windows from accepted pixels and checks the results.
	class pool_scoreboard;
		int unsigned      frame_rows;
		int unsigned      frame_cols;
		logic [PIX_W-2:0] top_best [PAIRS];
		bit               top_col_off [PAIRS];
		logic [PIX_W-2:0] left_hold;
		int unsigned      row_pos;
		int unsigned      col_pos;
		window_t          expected_windows [$];
		int unsigned      errors;

		function new();
			frame_rows = SIZE_MIN;
			frame_cols = SIZE_MIN;
			left_hold  = '0;
			row_pos    = 0;
			col_pos    = 0;
			errors     = 0;
			foreach (top_best[i]) begin
				top_best[i]    = '0;
				top_col_off[i] = 1'b0;
			end
		endfunction

		// Sizes below the minimum or above the maximum are pinned.
		function int unsigned fit_size(logic [CFG_W-1:0] v, int unsigned maxv);
			if (v < SIZE_MIN)
				return SIZE_MIN;
			if (32'(v) > maxv)
				return maxv;
			return 32'(v);
		endfunction

		// A write to a known register restarts the frame.
		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			if (idx == REG_IMAGE_ROWS) begin
				frame_rows = fit_size(data, MAX_R);
			end else if (idx == REG_IMAGE_COLS) begin
				frame_cols = fit_size(data, MAX_C);
			end else begin
				return;
			end
			row_pos = 0;
			col_pos = 0;
		endfunction

		function void note_pixel(logic [PIX_W-1:0] raw);
			logic [PIX_W-2:0] px;
			logic [PIX_W-2:0] best;
			logic             roff;
			logic             coff;
			int unsigned      pair;
			window_t          w;
			// Negative pixels never beat the zero start value.
			px   = raw[PIX_W-1] ? '0 : raw[PIX_W-2:0];
			pair = col_pos / 2;
			if (row_pos < frame_rows / 2 * 2 && col_pos < frame_cols / 2 * 2 && pair < PAIRS) begin
				if (col_pos % 2 == 0) begin
					left_hold = px;
				end else if (row_pos % 2 == 0) begin
					best = '0;
					coff = 1'b0;
					if (left_hold > best) begin
						best = left_hold;
						coff = 1'b0;
					end
					if (px > best) begin
						best = px;
						coff = 1'b1;
					end
					top_best[pair]    = best;
					top_col_off[pair] = coff;
				end else begin
					// Bottom right pixel closes the window.
					best = top_best[pair];
					roff = 1'b0;
					coff = top_col_off[pair];
					if (left_hold > best) begin
						best = left_hold;
						roff = 1'b1;
						coff = 1'b0;
					end
					if (px > best) begin
						best = px;
						roff = 1'b1;
						coff = 1'b1;
					end
					w.value   = best;
					w.row_off = roff;
					w.col_off = coff;
					w.row     = POS_W'(row_pos / 2);
					w.col     = POS_W'(pair);
					w.last    = (row_pos / 2 == frame_rows / 2 - 1) && (pair == frame_cols / 2 - 1);
					expected_windows.push_back(w);
				end
			end
			col_pos++;
			if (col_pos >= frame_cols) begin
				col_pos = 0;
				row_pos++;
				if (row_pos >= frame_rows)
					row_pos = 0;
			end
		endfunction

		function void check_result(window_t got);
			window_t want;
			if (expected_windows.size() == 0) begin
				errors++;
				if (errors <= SHOW_LIMIT)
					$display("%0t: result with no window pending: value %0d off (%0d,%0d) pos (%0d,%0d) last %0d",
						$time, got.value, got.row_off, got.col_off, got.row, got.col, got.last);
				return;
			end
			want = expected_windows.pop_front();
			if (got.value !== want.value || got.row_off !== want.row_off
					|| got.col_off !== want.col_off || got.row !== want.row
					|| got.col !== want.col || got.last !== want.last) begin
				errors++;
				if (errors <= SHOW_LIMIT) begin
					$display("%0t: window mismatch, expected value %0d off (%0d,%0d) pos (%0d,%0d) last %0d",
						$time, want.value, want.row_off, want.col_off, want.row, want.col, want.last);
					$display("%0t:                  actual value %0d off (%0d,%0d) pos (%0d,%0d) last %0d",
						$time, got.value, got.row_off, got.col_off, got.row, got.col, got.last);
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	int          tx_idle_pct;
	int          rx_idle_pct;
	bit          hold_req;
	int          hold_left;
	int unsigned cycles;

	pool_scoreboard sb = new();

	mpa_pix_if #(.PIX_WIDTH(PIX_W)) pix_ch ();
	mpa_res_if #(.PIX_WIDTH(PIX_W)) res_ch ();
	mpa_cfg_if                      cfg_ch ();

	max_pool_2x2_with_argmax dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixels  (pix_ch),
		.results (res_ch),
		.cfg     (cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Result side: random back-pressure, plus one long hold-off when asked.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			res_ch.ready <= 1'b0;
		end else if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYCLES;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// Observe every accepted request at the rising edge.
	always @(posedge clk) begin
		window_t got;
		got = {res_ch.pooled_value, res_ch.win_row_offset, res_ch.win_col_offset,
			res_ch.out_row, res_ch.out_col, res_ch.frame_last};
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				sb.write_reg(cfg_ch.index, cfg_ch.data);
			if (pix_ch.valid && pix_ch.ready)
				sb.note_pixel(pix_ch.pixel);
			if (res_ch.valid && res_ch.ready)
				sb.check_result(got);
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("max_pool_2x2_with_argmax_test: FAIL");
			$finish;
		end
	end

	// Offer one pixel, with random idle cycles ahead of it; returns once taken.
	task automatic send_pixel(logic [PIX_W-1:0] value);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			@(negedge clk);
			pix_ch.valid <= 1'b0;
		end
		@(negedge clk);
		pix_ch.valid <= 1'b1;
		pix_ch.pixel <= value;
		do @(posedge clk); while (!pix_ch.ready);
	endtask

	task automatic stop_pixels();
		@(negedge clk);
		pix_ch.valid <= 1'b0;
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Wait until every predicted window is out, then let the pipeline settle.
	task automatic wait_drained();
		do @(negedge clk); while (sb.expected_windows.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Mix of arbitrary, negative, small, tied and extreme pixels.
	function automatic logic [PIX_W-1:0] rand_pixel(logic [PIX_W-1:0] prev);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return PIX_W'($urandom);
			4, 5:       return {1'b1, (PIX_W-1)'($urandom)};
			6:          return PIX_W'($urandom_range(0, 15));
			7:          return prev;
			8: begin
				case ($urandom_range(0, 3))
					0:       return PIX_MAX;
					1:       return PIX_MIN;
					2:       return '0;
					default: return '1;
				endcase
			end
			default:    return {1'b0, (PIX_W-1)'($urandom)};
		endcase
	endfunction

	// Set both sizes in random order, sometimes with a write to an unused index.
	task automatic configure(logic [CFG_W-1:0] rows_val, logic [CFG_W-1:0] cols_val);
		if ($urandom_range(0, 3) == 0)
			write_cfg(CFG_IDX_W'($urandom_range(REG_IMAGE_COLS + 1, IDX_TOP)), CFG_W'($urandom));
		if ($urandom_range(0, 1)) begin
			write_cfg(REG_IMAGE_ROWS, rows_val);
			write_cfg(REG_IMAGE_COLS, cols_val);
		end else begin
			write_cfg(REG_IMAGE_COLS, cols_val);
			write_cfg(REG_IMAGE_ROWS, rows_val);
		end
		if ($urandom_range(0, 3) == 0)
			write_cfg(CFG_IDX_W'($urandom_range(REG_IMAGE_COLS + 1, IDX_TOP)), CFG_W'($urandom));
	endtask

	// One frame setting followed by a run of pixels, which may end mid-frame.
	task automatic run_phase(logic [CFG_W-1:0] rows_val, logic [CFG_W-1:0] cols_val,
			int n, bit pause_mid, bit hold_mid);
		logic [PIX_W-1:0] px;
		px = '0;
		wait_drained();
		configure(rows_val, cols_val);
		for (int i = 0; i < n; i++) begin
			if (hold_mid && i == n / 4)
				hold_req = 1'b1;
			if (pause_mid && i == n / 2) begin
				stop_pixels();
				wait_drained();
			end
			px = rand_pixel(px);
			send_pixel(px);
		end
		stop_pixels();
	endtask

	function automatic int eff_size(int v);
		return (v < SIZE_MIN) ? SIZE_MIN : v;
	endfunction

	// Windows at the reset size of 2x2: all negative, all zero, full tie, maximum at
	// top right, bottom left and bottom right, and a tie between top right and the bottom row.
	localparam logic [PIX_W-1:0] DIRECTED [28] = '{
		16'hFFFF, 16'h8000, 16'hFF00, 16'hFFFB,
		16'h0000, 16'h0000, 16'h0000, 16'h0000,
		16'h0007, 16'h0007, 16'h0007, 16'h0007,
		16'h0001, 16'h7FFF, 16'h0003, 16'h0002,
		16'h0004, 16'h0002, 16'h0064, 16'hFFFD,
		16'hFFFF, 16'h0003, 16'h0003, 16'h7FFF,
		16'h0002, 16'h0005, 16'h0005, 16'h0005
	};

	initial begin
		int rows_val;
		int cols_val;
		int n;
		int frame_px;
		int sent;
		int ph;
		arst_n        = 1'b0;
		pix_ch.valid  = 1'b0;
		pix_ch.pixel  = '0;
		res_ch.ready  = 1'b0;
		cfg_ch.valid  = 1'b0;
		cfg_ch.index  = REG_IMAGE_ROWS;
		cfg_ch.data   = '0;
		tx_idle_pct   = 0;
		rx_idle_pct   = 0;
		hold_req      = 1'b0;
		hold_left     = 0;
		cycles        = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed windows at the reset frame size.
		foreach (DIRECTED[i])
			send_pixel(DIRECTED[i]);
		stop_pixels();

		// Random frames under three idling patterns.
		for (int mode = 0; mode < 3; mode++) begin
			tx_idle_pct = (mode == 0) ? 18 : (mode == 1) ? 45 : 0;
			rx_idle_pct = (mode == 0) ? 45 : (mode == 1) ? 18 : 0;
			sent = 0;
			ph   = 0;
			while (sent < MODE_ITEMS) begin
				rows_val = $urandom_range(0, 9);
				cols_val = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40)
					: $urandom_range(0, 12);
				frame_px = eff_size(rows_val) * eff_size(cols_val);
				case ($urandom_range(0, 2))
					0:       n = frame_px * $urandom_range(1, 3);
					1:       n = $urandom_range(1, 2 * frame_px);
					default: n = frame_px + $urandom_range(1, 8);
				endcase
				// The last run of a pattern is cut to its share of pixels.
				if (n > MODE_ITEMS - sent)
					n = MODE_ITEMS - sent;
				run_phase(CFG_W'(rows_val), CFG_W'(cols_val), n,
					mode == 1 && ph == 0, mode != 1 && ph == 1);
				sent += n;
				ph++;
			end
		end

		// Widest and tallest frame settings, reached through out-of-range writes
		// too; only EDGE_ITEMS pixels of each are sent.
		run_phase(CFG_W'(0), CFG_W'(MAX_C), EDGE_ITEMS, 1'b0, 1'b0);
		run_phase(CFG_W'((1 << CFG_W) - 1), CFG_W'(1), EDGE_ITEMS, 1'b0, 1'b1);

		wait_drained();
		if (sb.errors == 0 && sb.expected_windows.size() == 0) begin
			$display("max_pool_2x2_with_argmax_test: PASS");
		end else begin
			$display("max_pool_2x2_with_argmax_test: FAIL");
		end
		$finish;
	end

endmodule

[max_pool_2x2_with_argmax.f]
rtl/mpa_pkg.sv
rtl/mpa_if.sv
rtl/mpa_pair_mem.sv
rtl/mpa_ctrl.sv
rtl/mpa_pool_stage.sv
rtl/max_pool_2x2_with_argmax.sv
tb/max_pool_2x2_with_argmax_test.sv
